// ===== rtl/urpq_pkg.sv =====
// Shared types and constants for the UART receive packetizer queue.
`default_nettype none
package urpq_pkg;

  localparam int unsigned DefBufferBytes = 256;
  localparam int unsigned DefQueueSlots  = 8;

  localparam int unsigned CfgW  = 9;
  localparam int unsigned LenW  = 9;
  localparam int unsigned OffW  = 8;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ModeW = 3;

  localparam logic [CfgW-1:0] MaxResetVal = 9'd128;

  typedef enum logic [ModeW-1:0] {
    MODE_BYTE  = 3'd0,
    MODE_IDLE  = 3'd1,
    MODE_DEQ   = 3'd2,
    MODE_READ  = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_e;

  typedef struct packed {
    logic accept;
    logic advance;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/uart_rx_packetizer_queue_unit.sv =====
// Top level of the UART receive packetizer with descriptor queue.
// One word is taken per clock cycle while the output is not stalled; each
// word gives one result word via the pending stage, which covers the
// registered byte store and descriptor RAM reads. A pending stage
// and an output register let the next word in while a result waits.
// No clearing pass runs after reset; the byte store and descriptor slots
// hold whatever was last written.
`default_nettype none
module uart_rx_packetizer_queue_unit #(
  parameter int unsigned BUFFER_BYTES = urpq_pkg::DefBufferBytes,
  parameter int unsigned QUEUE_SLOTS  = urpq_pkg::DefQueueSlots
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [15:0]                s_axis_tdata,  // rx_byte, read_address
  input  wire logic [2:0]                 s_axis_tuser,  // mode
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [31:0]                m_axis_tdata,  // desc_offset, desc_length, read_data
  output logic      [1:0]                 m_axis_tuser,  // packet_closed, desc_valid
  input  wire logic                       cfg_we_i,
  input  wire logic [urpq_pkg::CfgW-1:0]  cfg_wdata_i
);
  import urpq_pkg::*;

  ctrl_cmd_t        cmd;
  logic             closed, dvalid;
  logic [OffW-1:0]  offset;
  logic [LenW-1:0]  length;
  logic [ByteW-1:0] rdata;

  urpq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  urpq_dp #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .QUEUE_SLOTS  (QUEUE_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mode_i         (s_axis_tuser),
    .rx_byte_i      (s_axis_tdata[7:0]),
    .read_address_i (s_axis_tdata[15:8]),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .closed_o       (closed),
    .dvalid_o       (dvalid),
    .offset_o       (offset),
    .length_o       (length),
    .rdata_o        (rdata)
  );

  assign m_axis_tdata = {7'd0, rdata, length, offset};
  assign m_axis_tuser = {dvalid, closed};

endmodule
`default_nettype wire

// ===== rtl/urpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module urpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/urpq_ctrl.sv =====
// Handshake controller: tracks the pending and output stages.
`default_nettype none
module urpq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  output logic                    s_ready_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output urpq_pkg::ctrl_cmd_t     cmd_o
);
  import urpq_pkg::*;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_PEND  = 2'd1,
    ST_OUT   = 2'd2,
    ST_BOTH  = 2'd3
  } state_e;

  state_e state_q, state_d;
  logic   pend_full, out_full, advance, accept, pend_n, out_n;

  always_comb begin
    pend_full = (state_q == ST_PEND) || (state_q == ST_BOTH);
    out_full  = (state_q == ST_OUT)  || (state_q == ST_BOTH);
    advance   = pend_full && (!out_full || m_ready_i);
    s_ready_o = !pend_full || advance;
    accept    = s_valid_i && s_ready_o;
    pend_n    = accept || (pend_full && !advance);
    out_n     = advance || (out_full && !m_ready_i);
    unique case ({out_n, pend_n})
      2'b00:   state_d = ST_EMPTY;
      2'b01:   state_d = ST_PEND;
      2'b10:   state_d = ST_OUT;
      default: state_d = ST_BOTH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  assign m_valid_o      = out_full;
  assign cmd_o.accept   = accept;
  assign cmd_o.advance  = advance;

endmodule
`default_nettype wire

// ===== rtl/urpq_dp.sv =====
// Datapath: pointers, byte store, descriptor ring and result registers.
`default_nettype none
module urpq_dp #(
  parameter int unsigned BUFFER_BYTES = urpq_pkg::DefBufferBytes,
  parameter int unsigned QUEUE_SLOTS  = urpq_pkg::DefQueueSlots
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire urpq_pkg::ctrl_cmd_t           cmd_i,
  input  wire logic [urpq_pkg::ModeW-1:0]    mode_i,
  input  wire logic [urpq_pkg::ByteW-1:0]    rx_byte_i,
  input  wire logic [urpq_pkg::ByteW-1:0]    read_address_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [urpq_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic                               closed_o,
  output logic                               dvalid_o,
  output logic      [urpq_pkg::OffW-1:0]     offset_o,
  output logic      [urpq_pkg::LenW-1:0]     length_o,
  output logic      [urpq_pkg::ByteW-1:0]    rdata_o
);
  import urpq_pkg::*;

  localparam int unsigned AW  = $clog2(BUFFER_BYTES);
  localparam int unsigned PW  = AW + 1;
  localparam int unsigned QW  = $clog2(QUEUE_SLOTS);
  localparam int unsigned XW  = (PW > CfgW) ? PW : CfgW;
  localparam int unsigned RW  = (AW > ByteW) ? AW : ByteW;
  localparam int unsigned OXW = (PW > OffW) ? PW : OffW;
  localparam int unsigned DW  = OffW + LenW;

  logic [PW-1:0]   wp_q, wp_d, ps_q, ps_d;
  logic [QW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CfgW-1:0] max_q;
  logic            pend_closed_q, pend_closed_d;
  logic            pend_dvalid_q, pend_dvalid_d;
  logic            pend_rd_q, pend_rd_d;

  logic [XW-1:0]   max_x, lim_x, len_x;
  logic [PW-1:0]   limit, wp_inc, fill, close_len, ps_sum;
  logic [OXW-1:0]  off_x;
  logic [RW-1:0]   ra_x;
  logic [PW:0]     wrap_sum;
  logic            wrap, do_close, full_hit;
  logic [QW-1:0]   head_next, tail_next;
  logic            byte_we, byte_re, q_re;
  logic [DW-1:0]   q_wdata, q_rdata;
  logic [ByteW-1:0] b_rdata;
  mode_e           mode;

  always_comb begin
    mode      = mode_e'(mode_i);
    max_x     = XW'(max_q);
    if (max_x == '0) begin
      lim_x = XW'(1);
    end else if (max_x > XW'(BUFFER_BYTES)) begin
      lim_x = XW'(BUFFER_BYTES);
    end else begin
      lim_x = max_x;
    end
    limit     = lim_x[PW-1:0];
    wp_inc    = wp_q + PW'(1);
    fill      = wp_inc - ps_q;
    full_hit  = fill >= limit;
    close_len = (mode == MODE_BYTE) ? limit : (wp_q - ps_q);
    ps_sum    = ps_q + close_len;
    wrap_sum  = {1'b0, ps_sum} + {1'b0, limit};
    wrap      = wrap_sum > (PW+1)'(BUFFER_BYTES);
    len_x     = XW'(close_len);
    off_x     = OXW'(ps_q);
    ra_x      = RW'(read_address_i);
    head_next = (head_q == QW'(QUEUE_SLOTS - 1)) ? '0 : head_q + QW'(1);
    tail_next = (tail_q == QW'(QUEUE_SLOTS - 1)) ? '0 : tail_q + QW'(1);
    q_wdata   = {len_x[LenW-1:0], off_x[OffW-1:0]};

    wp_d          = wp_q;
    ps_d          = ps_q;
    head_d        = head_q;
    tail_d        = tail_q;
    do_close      = 1'b0;
    byte_we       = 1'b0;
    byte_re       = 1'b0;
    q_re          = 1'b0;
    pend_closed_d = pend_closed_q;
    pend_dvalid_d = pend_dvalid_q;
    pend_rd_d     = pend_rd_q;

    if (cmd_i.accept) begin
      pend_closed_d = 1'b0;
      pend_dvalid_d = 1'b0;
      pend_rd_d     = 1'b0;
      unique case (mode)
        MODE_BYTE: begin
          byte_we  = 1'b1;
          wp_d     = wp_inc;
          do_close = full_hit;
        end
        MODE_IDLE: begin
          do_close = wp_q != ps_q;
        end
        MODE_DEQ: begin
          if (head_q != tail_q) begin
            head_d        = head_next;
            q_re          = 1'b1;
            pend_dvalid_d = 1'b1;
          end
        end
        MODE_READ: begin
          byte_re   = 1'b1;
          pend_rd_d = 1'b1;
        end
        MODE_CLEAR: begin
          wp_d   = '0;
          ps_d   = '0;
          head_d = '0;
          tail_d = '0;
        end
        default: begin
        end
      endcase
      if (do_close) begin
        pend_closed_d = 1'b1;
        tail_d        = tail_next;
        if (wrap) begin
          ps_d = '0;
          wp_d = '0;
        end else begin
          ps_d = ps_sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q          <= '0;
      ps_q          <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      max_q         <= MaxResetVal;
      pend_closed_q <= 1'b0;
      pend_dvalid_q <= 1'b0;
      pend_rd_q     <= 1'b0;
    end else begin
      wp_q          <= wp_d;
      ps_q          <= ps_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      pend_closed_q <= pend_closed_d;
      pend_dvalid_q <= pend_dvalid_d;
      pend_rd_q     <= pend_rd_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  urpq_ram #(
    .WIDTH (ByteW),
    .DEPTH (BUFFER_BYTES)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (wp_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (byte_re),
    .raddr_i (ra_x[AW-1:0]),
    .rdata_o (b_rdata)
  );

  urpq_ram #(
    .WIDTH (DW),
    .DEPTH (QUEUE_SLOTS)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (do_close),
    .waddr_i (tail_next),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (head_next),
    .rdata_o (q_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      closed_o <= pend_closed_q;
      dvalid_o <= pend_dvalid_q;
      offset_o <= pend_dvalid_q ? q_rdata[OffW-1:0] : '0;
      length_o <= pend_dvalid_q ? q_rdata[DW-1:OffW] : '0;
      rdata_o  <= pend_rd_q ? b_rdata : '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/urpq_assert.sv =====
// Port-level checks for the packetizer top level, bound to it.
`default_nettype none
module urpq_assert (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_word_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |-> ##2 m_axis_tvalid)
    else $error("accepted word did not reach the output");

  a_close_xor_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("close and dequeue flagged in one word");

  a_empty_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[16:0] == 17'd0)
    else $error("descriptor fields set without a valid descriptor");

  a_read_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[24:17] != 8'd0) |-> m_axis_tuser == 2'b00)
    else $error("read data mixed with close or dequeue");

endmodule

bind uart_rx_packetizer_queue_unit urpq_assert u_urpq_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== verif/uart_rx_packetizer_queue_unit_test.sv =====
// Self-checking stream testbench for the UART receive packetizer queue unit.
module uart_rx_packetizer_queue_unit_test;
  import urpq_pkg::*;

  localparam int unsigned StoreBytes = DefBufferBytes;
  localparam int unsigned SlotCount  = DefQueueSlots;
  localparam logic [ModeW-1:0] ModeSpare5 = 3'd5;
  localparam logic [ModeW-1:0] ModeSpare6 = 3'd6;
  localparam logic [ModeW-1:0] ModeSpare7 = 3'd7;
  localparam int unsigned ReportLimit = 10;

  typedef struct {
    logic [ModeW-1:0] mode;
    logic [ByteW-1:0] rx_byte;
    logic [OffW-1:0]  rd_addr;
  } rx_word_t;

  typedef struct {
    logic             closed;
    logic             dvalid;
    logic [OffW-1:0]  offset;
    logic [LenW-1:0]  length;
    logic [ByteW-1:0] rdata;
  } rx_result_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [15:0]     s_axis_tdata  = '0;
  logic [2:0]      s_axis_tuser  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [31:0]     m_axis_tdata;
  logic [1:0]      m_axis_tuser;
  logic            cfg_we_i      = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i   = '0;

  uart_rx_packetizer_queue_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Mirror of the packetizer state.
  logic [ByteW-1:0] store_mirror [StoreBytes];
  bit               store_written [StoreBytes];
  logic [OffW-1:0]  slot_off [SlotCount];
  logic [LenW-1:0]  slot_len [SlotCount];
  int unsigned      wr_ptr, pkt_start, q_head, q_tail;
  int unsigned      max_setting = MaxResetVal;

  rx_word_t    pending_words [$];
  rx_result_t  expected_results [$];
  rx_word_t    cur_word;
  rx_result_t  want, got;
  int unsigned words_taken, mismatches;
  int unsigned burst_left, gap_left;
  bit          drain_hold;
  logic        calm = 1'b0;
  logic [31:0] cycle_count = '0;
  int unsigned stall_left = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned active_limit();
    int unsigned lim;
    lim = max_setting;
    if (lim == 0) lim = 1;
    if (lim > StoreBytes) lim = StoreBytes;
    return lim;
  endfunction

  function automatic void close_packet(int unsigned len, int unsigned lim);
    q_tail = (q_tail + 1) % SlotCount;
    slot_off[q_tail] = OffW'(pkt_start);
    slot_len[q_tail] = LenW'(len);
    pkt_start += len;
    if (pkt_start + lim > StoreBytes) begin
      pkt_start = 0;
      wr_ptr = 0;
    end
  endfunction

  function automatic rx_result_t predict_result(rx_word_t w);
    rx_result_t  r;
    int unsigned lim;
    r = '{closed: 1'b0, dvalid: 1'b0, offset: '0, length: '0, rdata: '0};
    lim = active_limit();
    case (w.mode)
      MODE_BYTE: begin
        store_mirror[wr_ptr % StoreBytes] = w.rx_byte;
        store_written[wr_ptr % StoreBytes] = 1'b1;
        wr_ptr++;
        if (wr_ptr - pkt_start >= lim) begin
          close_packet(lim, lim);
          r.closed = 1'b1;
        end
      end
      MODE_IDLE: begin
        if (wr_ptr != pkt_start) begin
          close_packet(wr_ptr - pkt_start, lim);
          r.closed = 1'b1;
        end
      end
      MODE_DEQ: begin
        if (q_tail != q_head) begin
          q_head = (q_head + 1) % SlotCount;
          r.dvalid = 1'b1;
          r.offset = slot_off[q_head];
          r.length = slot_len[q_head];
        end
      end
      MODE_READ: r.rdata = store_mirror[w.rd_addr];
      MODE_CLEAR: begin
        wr_ptr = 0;
        pkt_start = 0;
        q_head = 0;
        q_tail = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Steer reads onto store bytes that hold data.
  function automatic logic [OffW-1:0] written_addr(logic [OffW-1:0] addr);
    int unsigned start, i;
    if (store_written[addr]) return addr;
    start = $urandom_range(0, StoreBytes - 1);
    for (i = 0; i < StoreBytes; i++) begin
      if (store_written[(start + i) % StoreBytes]) return OffW'((start + i) % StoreBytes);
    end
    return addr;
  endfunction

  function automatic void push_word(logic [ModeW-1:0] mode, logic [ByteW-1:0] rx,
                                    logic [OffW-1:0] addr);
    rx_word_t w;
    w.mode = mode;
    w.rx_byte = rx;
    w.rd_addr = addr;
    pending_words.push_back(w);
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max(int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CfgW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_setting = value;
  endtask

  task automatic queue_random_traffic(int unsigned count);
    int unsigned made, n, k, lim, i;
    made = 0;
    lim = active_limit();
    while (made < count) begin
      k = $urandom_range(0, 99);
      if (k < 65) begin
        if (lim <= 12 || $urandom_range(0, 3) == 0)
          n = $urandom_range(1, (lim < 40) ? lim + 2 : 40);
        else
          n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) push_word(MODE_BYTE, 8'($urandom), 8'($urandom));
        made += n;
        if ($urandom_range(0, 3) != 0) begin
          push_word(MODE_IDLE, 8'($urandom), 8'($urandom));
          made++;
        end
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) push_word(MODE_DEQ, 8'($urandom), 8'($urandom));
        made += n;
        if ($urandom_range(0, 1) == 1) begin
          push_word(MODE_READ, 8'($urandom), 8'($urandom));
          made++;
        end
      end else if (k < 77) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) push_word(MODE_DEQ, 8'($urandom), 8'($urandom));
        made += n;
      end else if (k < 86) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) push_word(MODE_READ, 8'($urandom), 8'($urandom));
        made += n;
      end else if (k < 91) begin
        push_word(MODE_IDLE, 8'($urandom), 8'($urandom));
        made++;
      end else if (k < 96) begin
        push_word(ModeW'(ModeSpare5 + $urandom_range(0, 2)), 8'($urandom), 8'($urandom));
        made++;
      end else begin
        push_word(MODE_CLEAR, 8'($urandom), 8'($urandom));
        made++;
      end
    end
    // Leave a packet open across the setting change.
    n = $urandom_range(1, 8);
    for (i = 0; i < n; i++) push_word(MODE_BYTE, 8'($urandom), 8'($urandom));
  endtask

  // Sender: bursts of words from the pending queue.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_result(cur_word));
        words_taken++;
        if (words_taken % 300 == 150) drain_hold = 1'b1;
      end
      if (drain_hold && expected_results.size() == 0) drain_hold = 1'b0;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || drain_hold || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_word = pending_words.pop_front();
          if (cur_word.mode == MODE_READ) cur_word.rd_addr = written_addr(cur_word.rd_addr);
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_word.mode;
          s_axis_tdata <= {cur_word.rd_addr, cur_word.rx_byte};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 11);
            gap_left = calm ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: stall pattern with quiet stretches.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[7:0] == 8'hff) calm <= ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 2) == 0) begin
      stall_left <= $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.closed = m_axis_tuser[0];
      got.dvalid = m_axis_tuser[1];
      got.offset = m_axis_tdata[7:0];
      got.length = m_axis_tdata[16:8];
      got.rdata  = m_axis_tdata[24:17];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result word: tuser=%b tdata=%h", m_axis_tuser, m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got.closed !== want.closed || got.dvalid !== want.dvalid ||
            got.offset !== want.offset || got.length !== want.length ||
            got.rdata !== want.rdata) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("mismatch: expected closed=%0d valid=%0d off=%0d len=%0d data=%0d,",
                     want.closed, want.dvalid, want.offset, want.length, want.rdata,
                     " got closed=%0d valid=%0d off=%0d len=%0d data=%0d",
                     got.closed, got.dvalid, got.offset, got.length, got.rdata);
        end
      end
    end
  end

  initial begin
    int unsigned settings [11];
    int unsigned i;
    settings = '{0, 16, 128, 511, 5, 257, 2, 64, 200, 3, 256};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_word(MODE_DEQ, 8'h00, 8'h00);
    push_word(ModeSpare5, 8'hff, 8'hff);
    push_word(ModeSpare6, 8'h00, 8'hff);
    push_word(ModeSpare7, 8'hff, 8'h00);
    push_word(MODE_BYTE, 8'h00, 8'hff);
    push_word(MODE_BYTE, 8'hff, 8'h00);
    push_word(MODE_BYTE, 8'h5a, 8'ha5);
    push_word(MODE_READ, 8'hff, 8'h00);
    push_word(MODE_READ, 8'h00, 8'h01);
    push_word(MODE_IDLE, 8'h00, 8'h00);
    push_word(MODE_IDLE, 8'h00, 8'h00);
    push_word(MODE_DEQ, 8'h00, 8'h00);
    push_word(MODE_BYTE, 8'hc3, 8'h00);
    push_word(MODE_BYTE, 8'h3c, 8'h00);
    push_word(MODE_CLEAR, 8'h00, 8'h00);
    push_word(MODE_IDLE, 8'h00, 8'h00);
    push_word(MODE_READ, 8'h00, 8'h00);

    // Overrun the descriptor ring with single-byte packets.
    wait_idle();
    write_max(1);
    for (i = 0; i < SlotCount; i++) push_word(MODE_BYTE, 8'(i), 8'h00);
    push_word(MODE_DEQ, 8'h00, 8'h00);
    push_word(MODE_BYTE, 8'h81, 8'h00);
    push_word(MODE_DEQ, 8'h00, 8'h00);

    foreach (settings[p]) begin
      wait_idle();
      write_max(settings[p]);
      if (settings[p] == 511) begin
        // Grow the open packet past the end of the store.
        for (i = 0; i < 150; i++) push_word(MODE_BYTE, 8'($urandom), 8'($urandom));
        push_word(MODE_IDLE, 8'h00, 8'h00);
      end
      queue_random_traffic(55);
      if (settings[p] == 128) begin
        push_word(MODE_CLEAR, 8'h00, 8'h00);
        for (i = 0; i < 178; i++) push_word(MODE_BYTE, 8'($urandom), 8'($urandom));
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/urpq_pkg.sv
rtl/urpq_ram.sv
rtl/urpq_ctrl.sv
rtl/urpq_dp.sv
rtl/uart_rx_packetizer_queue_unit.sv
rtl/urpq_assert.sv
verif/uart_rx_packetizer_queue_unit_test.sv
